[sv/assert_macros.svh]
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet in reset
`define CHK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// next-cycle implication, quiet in reset
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

[sv/sws_pkg.sv]
package sws_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int IDX_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W = IDX_W + 1;
  localparam int VAL_W = 32;
  localparam int SUM_W = VAL_W + IDX_W;
  localparam int SQ_W = 2 * VAL_W;
  localparam int SQSUM_W = SQ_W + IDX_W;
  localparam int DIV_W = SQSUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int ROOT_W = SQ_W / 2;
  localparam int ROOT_CNT_W = $clog2(ROOT_W);
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = CFG_IDX_W'(1);
  localparam logic [31:0] WINDOW_RESET = 32'd5000000;

  typedef enum logic [3:0] {
    S_IDLE, S_APPEND, S_EV_RD, S_EV_CHK, S_P1, S_MEAN_GO, S_MEAN_WAIT,
    S_P2, S_VAR_GO, S_VAR_WAIT, S_SQRT, S_DONE
  } state_t;

  typedef struct packed {
    logic               done;
    logic [DIV_W-1:0]   quo;
    logic [CNT_W-1:0]   rem;
  } div_res_t;

endpackage

[sv/sws_if.sv]
interface sws_in_if;
  import sws_pkg::*;
  logic valid;
  logic ready;
  logic [31:0] arrival_time;
  logic signed [31:0] sample_value;
  modport source(output valid, arrival_time, sample_value, input ready);
  modport sink(input valid, arrival_time, sample_value, output ready);
endinterface

interface sws_out_if;
  import sws_pkg::*;
  logic valid;
  logic ready;
  logic [CNT_W-1:0] sample_count;
  logic signed [31:0] mean_value;
  logic signed [31:0] min_value;
  logic signed [31:0] max_value;
  logic [31:0] std_dev;
  logic overflow_flag;
  modport source(output valid, sample_count, mean_value, min_value, max_value,
                 std_dev, overflow_flag, input ready);
  modport sink(input valid, sample_count, mean_value, min_value, max_value,
               std_dev, overflow_flag, output ready);
endinterface

interface sws_cfg_if;
  import sws_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[sv/sws_div.sv]
module sws_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [sws_pkg::DIV_W-1:0] dividend,
  input  logic [sws_pkg::CNT_W-1:0] divisor,
  output sws_pkg::div_res_t        res
);
  import sws_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     quo;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     dsr;
  logic                 done;
  logic [CNT_W:0]       shifted;
  logic                 fits;

  // restoring division, one quotient bit a cycle
  assign shifted = {rem, quo[DIV_W-1]};
  assign fits = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= CNT_W'(shifted - {1'b0, dsr});
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= shifted[CNT_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign res.done = done;
  assign res.quo = quo;
  assign res.rem = rem;
endmodule

[sv/sliding_window_statistics.sv]
// channel  dir  handshake      payload
// sample   in   valid/ready    arrival_time, sample_value
// stats    out  valid/ready    sample_count, mean_value, min_value, max_value,
//                              std_dev, overflow_flag
// cfg      in   valid/ready    index, data (ready always high)
// one item at a time; the time from acceptance to result grows with the evictions and is set by
// the two passes over the value ring (one read a cycle), two 74-step divisions and a
// 32-step square root. reset is synchronous; the rings need no clearing.
// the next item is taken while a result waits on a stalled stats channel.
module sliding_window_statistics (
  input  logic      clk,
  input  logic      rst,
  sws_in_if.sink    sample,
  sws_out_if.source stats,
  sws_cfg_if.sink   cfg
);
  import sws_pkg::*;

  logic [31:0]        ring_times [MAX_SAMPLES];
  logic [VAL_W-1:0]   ring_values [MAX_SAMPLES];
  logic [31:0]        time_q;
  logic signed [VAL_W-1:0] val_q;

  state_t state, state_next;

  logic [31:0]        window;
  logic               interval;
  logic [31:0]        t_in;
  logic signed [VAL_W-1:0] v_in;
  logic [31:0]        prev_arr;
  logic               have_prev;
  logic [IDX_W-1:0]   oldest;
  logic [CNT_W-1:0]   count;
  logic               flag;

  logic [CNT_W-1:0]   iss;
  logic               p_vld, v1, v2;
  logic signed [SUM_W-1:0] sum;
  logic signed [VAL_W-1:0] vmin, vmax;
  logic signed [VAL_W-1:0] mean;
  logic [VAL_W-1:0]   dabs;
  logic [SQ_W-1:0]    sq;
  logic [SQSUM_W-1:0] sq_sum;
  logic [SQ_W-1:0]    rad;
  logic [ROOT_W+1:0]  srem;
  logic [ROOT_W-1:0]  root;
  logic [ROOT_CNT_W-1:0] sq_cnt;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W-1:0]   rd_addr;
  logic signed [VAL_W-1:0] v_new;
  logic               full;
  logic [IDX_W-1:0]   oldest_a;
  logic [CNT_W-1:0]   count_a;
  logic signed [VAL_W:0] gap;
  logic               expired;
  logic               issue;
  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  div_res_t           div_res;
  logic [SUM_W-1:0]   sum_mag;
  logic [SUM_W-1:0]   mean_wide;
  logic signed [VAL_W:0] diff;
  logic [ROOT_W+3:0]  s_shift;
  logic [ROOT_W+3:0]  s_trial;
  logic               out_free;

  assign sample.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign out_free = !stats.valid || stats.ready;

  // sample of this item
  assign gap = $signed({1'b0, t_in}) - $signed({1'b0, prev_arr});
  always_comb begin
    if (!interval) begin
      v_new = v_in;
    end else if (gap[VAL_W] != gap[VAL_W-1]) begin
      v_new = gap[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      v_new = gap[VAL_W-1:0];
    end
  end

  assign full = count[CNT_W-1];
  assign oldest_a = full ? oldest + 1'b1 : oldest;
  assign count_a = full ? CNT_W'(MAX_SAMPLES - 1) : count;
  assign wr_addr = oldest_a + count_a[IDX_W-1:0];
  assign wr_en = (state == S_APPEND) && !(interval && !have_prev);
  assign expired = (count != '0) &&
                   ({1'b0, time_q} + {1'b0, window} < {1'b0, t_in});
  assign issue = ((state == S_P1) || (state == S_P2)) && (iss < count);
  assign rd_addr = (state == S_EV_RD) ? oldest : oldest + iss[IDX_W-1:0];

  assign sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign div_start = (state == S_MEAN_GO) || (state == S_VAR_GO);
  assign div_dividend = (state == S_MEAN_GO) ? DIV_W'(sum_mag) : sq_sum;
  assign mean_wide = SUM_W'(div_res.quo) + SUM_W'(div_res.rem != '0);
  assign diff = $signed({val_q[VAL_W-1], val_q}) - $signed({mean[VAL_W-1], mean});

  assign s_shift = {srem, rad[SQ_W-1:SQ_W-2]};
  assign s_trial = {2'b00, root, 2'b01};

  sws_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_times[wr_addr] <= t_in;
      ring_values[wr_addr] <= v_new;
    end
    time_q <= ring_times[rd_addr];
    val_q <= ring_values[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (sample.valid) state_next = S_APPEND;
      S_APPEND: state_next = (interval && !have_prev) ? S_IDLE : S_EV_RD;
      S_EV_RD: state_next = S_EV_CHK;
      S_EV_CHK: state_next = expired ? S_EV_RD : S_P1;
      S_P1: if (iss == count && !p_vld) state_next = S_MEAN_GO;
      S_MEAN_GO: state_next = S_MEAN_WAIT;
      S_MEAN_WAIT: if (div_res.done) state_next = S_P2;
      S_P2: if (iss == count && !p_vld && !v1 && !v2) state_next = S_VAR_GO;
      S_VAR_GO: state_next = S_VAR_WAIT;
      S_VAR_WAIT: if (div_res.done) state_next = S_SQRT;
      S_SQRT: if (sq_cnt == ROOT_CNT_W'(ROOT_W - 1)) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
      interval <= 1'b0;
      prev_arr <= '0;
      have_prev <= 1'b0;
      oldest <= '0;
      count <= '0;
      stats.valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.index == REG_WINDOW) window <= cfg.data;
      if (cfg.valid && cfg.index == REG_INTERVAL) interval <= cfg.data[0];
      if (state == S_APPEND && interval) begin
        prev_arr <= t_in;
        have_prev <= 1'b1;
      end
      if (wr_en) begin
        oldest <= oldest_a;
        count <= count_a + 1'b1;
      end
      if (state == S_EV_CHK && expired) begin
        oldest <= oldest + 1'b1;
        count <= count - 1'b1;
      end
      if (state == S_DONE && out_free) begin
        stats.valid <= 1'b1;
      end else if (stats.ready) begin
        stats.valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      t_in <= sample.arrival_time;
      v_in <= sample.sample_value;
    end
    if (wr_en) flag <= full;
    p_vld <= issue;
    if (issue) iss <= iss + 1'b1;
    case (state)
      S_EV_CHK: begin
        iss <= '0;
        sum <= '0;
        vmin <= {1'b0, {(VAL_W-1){1'b1}}};
        vmax <= {1'b1, {(VAL_W-1){1'b0}}};
      end
      S_P1: begin
        if (p_vld) begin
          sum <= sum + SUM_W'(val_q);
          if (val_q < vmin) vmin <= val_q;
          if (val_q > vmax) vmax <= val_q;
        end
      end
      S_MEAN_WAIT: begin
        iss <= '0;
        v1 <= 1'b0;
        v2 <= 1'b0;
        sq_sum <= '0;
        if (div_res.done) begin
          mean <= sum[SUM_W-1] ? VAL_W'(-mean_wide) : VAL_W'(div_res.quo);
        end
      end
      S_P2: begin
        v1 <= p_vld;
        v2 <= v1;
        dabs <= diff[VAL_W] ? VAL_W'(-diff) : VAL_W'(diff);
        sq <= dabs * dabs;
        if (v2) sq_sum <= sq_sum + SQSUM_W'(sq);
      end
      S_VAR_WAIT: begin
        srem <= '0;
        root <= '0;
        sq_cnt <= '0;
        // quotient fits 64 bits for any window; saturate anyway
        rad <= (div_res.quo[DIV_W-1:SQ_W] != '0) ? '1 : div_res.quo[SQ_W-1:0];
      end
      S_SQRT: begin
        sq_cnt <= sq_cnt + 1'b1;
        rad <= {rad[SQ_W-3:0], 2'b00};
        if (s_shift >= s_trial) begin
          srem <= (ROOT_W+2)'(s_shift - s_trial);
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          srem <= s_shift[ROOT_W+1:0];
          root <= {root[ROOT_W-2:0], 1'b0};
        end
      end
      S_DONE: begin
        if (out_free) begin
          stats.sample_count <= count;
          stats.mean_value <= mean;
          stats.min_value <= vmin;
          stats.max_value <= vmax;
          stats.std_dev <= root;
          stats.overflow_flag <= flag;
        end
      end
      default: begin
      end
    endcase
  end
endmodule

[sv/sws_check.sv]
module sws_check (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [10:0]       count,
  input logic signed [31:0] mean,
  input logic signed [31:0] vmin,
  input logic signed [31:0] vmax,
  input logic [31:0]       sdev
);
`include "assert_macros.svh"

  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mean))
  `CHK_NOW(a_count_range, out_valid, count != 11'd0 && count <= 11'd1024)
  `CHK_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `CHK_NOW(a_single, out_valid && count == 11'd1, sdev == 32'd0 && vmin == vmax && mean == vmin)
  `CHK_NOW(a_order, out_valid, vmin <= mean && mean <= vmax)
endmodule

bind sliding_window_statistics sws_check u_sws_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .out_valid (stats.valid),
  .out_ready (stats.ready),
  .count     (stats.sample_count),
  .mean      (stats.mean_value),
  .vmin      (stats.min_value),
  .vmax      (stats.max_value),
  .sdev      (stats.std_dev)
);

[verif/tb_sliding_window_statistics.sv]
module tb_sliding_window_statistics;
  import sws_pkg::*;

  localparam int RING_DEPTH = MAX_SAMPLES;
  localparam int STALL_LIMIT = 400000;

  typedef struct packed {
    logic [CNT_W-1:0]   sample_count;
    logic signed [31:0] mean_value;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic [31:0]        std_dev;
    logic               overflow_flag;
  } stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sws_in_if  sample();
  sws_out_if stats();
  sws_cfg_if cfg();

  sliding_window_statistics dut (
    .clk(clk), .rst(rst), .sample(sample), .stats(stats), .cfg(cfg)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0]        win_times [RING_DEPTH];
  logic signed [31:0] win_values [RING_DEPTH];
  int unsigned        win_oldest;
  int unsigned        win_count;
  logic [31:0]        last_arrival;
  bit                 have_last;
  logic [31:0]        window_len;
  bit                 gap_mode;

  stats_t expected_stats[$];
  int     error_count;
  int     results_seen;
  int     items_sent;
  int     send_idle_pct;
  int     recv_idle_pct;
  bit     recv_hold;
  int     quiet_cycles;
  logic [31:0] next_time;

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  task automatic predict_window(input logic [31:0] t, input logic signed [31:0] sv);
    logic signed [31:0] v;
    logic signed [63:0] gap;
    logic signed [63:0] total;
    logic signed [63:0] mean;
    logic signed [63:0] d;
    logic [127:0] sq_sum;
    logic [127:0] var_q;
    logic [63:0]  var_c;
    logic [63:0]  root_c;
    logic signed [31:0] vmin;
    logic signed [31:0] vmax;
    bit flag;
    int unsigned pos;
    stats_t r;
    flag = 0;
    if (gap_mode) begin
      if (!have_last) begin
        have_last = 1;
        last_arrival = t;
        return;
      end
      gap = $signed({32'd0, t}) - $signed({32'd0, last_arrival});
      if (gap > 64'sd2147483647) gap = 64'sd2147483647;
      if (gap < -64'sd2147483648) gap = -64'sd2147483648;
      v = gap[31:0];
      last_arrival = t;
    end else begin
      v = sv;
    end
    if (win_count >= RING_DEPTH) begin
      win_oldest = (win_oldest + 1) % RING_DEPTH;
      win_count = RING_DEPTH - 1;
      flag = 1;
    end
    pos = (win_oldest + win_count) % RING_DEPTH;
    win_times[pos] = t;
    win_values[pos] = v;
    win_count++;
    while (win_count > 0 &&
           ({32'd0, win_times[win_oldest]} + {32'd0, window_len}) < {32'd0, t}) begin
      win_oldest = (win_oldest + 1) % RING_DEPTH;
      win_count--;
    end
    vmin = win_values[win_oldest];
    vmax = vmin;
    total = 0;
    for (int i = 0; i < win_count; i++) begin
      v = win_values[(win_oldest + i) % RING_DEPTH];
      total += v;
      if (v < vmin) vmin = v;
      if (v > vmax) vmax = v;
    end
    // floor division, rounding towards minus infinity
    if (total >= 0) mean = total / $signed({32'd0, win_count});
    else mean = -((-total + win_count - 1) / $signed({32'd0, win_count}));
    sq_sum = 0;
    for (int i = 0; i < win_count; i++) begin
      d = win_values[(win_oldest + i) % RING_DEPTH] - mean;
      if (d < 0) d = -d;
      sq_sum += {64'd0, d[63:0]} * {64'd0, d[63:0]};
    end
    var_q = sq_sum / win_count;
    var_c = (var_q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : var_q[63:0];
    root_c = floor_sqrt(var_c);
    r.sample_count = win_count[CNT_W-1:0];
    r.mean_value = mean[31:0];
    r.min_value = vmin;
    r.max_value = vmax;
    r.std_dev = root_c[31:0];
    r.overflow_flag = flag;
    expected_stats.push_back(r);
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    error_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    stats_t got, exp_r;
    if (!rst && stats.valid && stats.ready) begin
      got = {stats.sample_count, stats.mean_value, stats.min_value, stats.max_value,
             stats.std_dev, stats.overflow_flag};
      results_seen++;
      if (expected_stats.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        exp_r = expected_stats[0];
        expected_stats.delete(0);
        if (got.sample_count !== exp_r.sample_count)
          report_mismatch($sformatf("count %0d exp %0d", got.sample_count,
                                    exp_r.sample_count));
        if (got.mean_value !== exp_r.mean_value)
          report_mismatch($sformatf("mean %0d exp %0d", got.mean_value, exp_r.mean_value));
        if (got.min_value !== exp_r.min_value)
          report_mismatch($sformatf("min %0d exp %0d", got.min_value, exp_r.min_value));
        if (got.max_value !== exp_r.max_value)
          report_mismatch($sformatf("max %0d exp %0d", got.max_value, exp_r.max_value));
        if (got.std_dev !== exp_r.std_dev)
          report_mismatch($sformatf("std %0d exp %0d", got.std_dev, exp_r.std_dev));
        if (got.overflow_flag !== exp_r.overflow_flag)
          report_mismatch($sformatf("flag %0b exp %0b", got.overflow_flag,
                                    exp_r.overflow_flag));
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (rst) stats.ready <= 1'b0;
    else if (recv_hold) stats.ready <= 1'b0;
    else stats.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((sample.valid && sample.ready) || (stats.valid && stats.ready) ||
        (cfg.valid && cfg.ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("watchdog expired");
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic [31:0] t, input logic signed [31:0] v);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    sample.valid = 1'b1;
    sample.arrival_time <= t;
    sample.sample_value <= v;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    predict_window(t, v);
    items_sent++;
    @(negedge clk);
    sample.valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg.valid = 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    if (idx == REG_WINDOW) window_len = data;
    else if (idx == REG_INTERVAL) gap_mode = data[0];
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (expected_stats.size() != 0) @(negedge clk);
    // an interval-mode first arrival gives no result but may still be in work
    repeat (2 * RING_DEPTH + 400) @(negedge clk);
  endtask

  task automatic test_directed();
    send_item(32'd0, 32'sh7FFF_FFFF);
    send_item(32'd1, 32'sh8000_0000);
    send_item(32'd2, 32'sh7FFF_FFFF);
    send_item(32'd3, 32'sh8000_0000);
    send_item(32'd3, 32'sd0);
    send_item(32'd3, -32'sd1);
    send_item(32'd9_000_000, 32'sd5);     // evicts everything older
    send_item(32'd8_000_000, 32'sd6);     // time going backwards
    wait_idle();
    write_reg(REG_WINDOW, 32'd0);         // zero window
    send_item(32'd9_000_000, 32'sd1);
    send_item(32'd9_000_000, 32'sd2);
    send_item(32'd9_000_001, 32'sd3);
    wait_idle();
    write_reg(REG_WINDOW, 32'hFFFF_FFFF);
    write_reg(CFG_IDX_W'(7), 32'd1);      // unknown index, ignored
    write_reg(REG_INTERVAL, 32'd1);
    send_item(32'd10, 32'sd0);            // first arrival, no result
    send_item(32'hFFFF_FFFF, 32'sd0);     // gap saturates high
    send_item(32'd0, 32'sd0);             // gap saturates low
    send_item(32'd100, 32'sd0);
    wait_idle();
    write_reg(REG_INTERVAL, 32'd0);
    send_item(32'hFFFF_FFFF, 32'sd0);
    send_item(32'hFFFF_FFFF, 32'shFFFF_FFFF);
    wait_idle();
  endtask

  task automatic test_long_window();
    // earlier times with the full window: nothing expires, the ring grows
    write_reg(REG_WINDOW, 32'hFFFF_FFFF);
    for (int i = 0; i < 12; i++) send_item(32'd4000 + i, $urandom());
    wait_idle();
  endtask

  task automatic test_random(input int n);
    logic signed [31:0] v;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) next_time = $urandom();
      else next_time = next_time + $urandom_range(2000);
      case ($urandom_range(3))
        0: v = $urandom();
        1: v = $signed($urandom_range(200)) - 100;
        2: v = $urandom_range(1) ? 32'sh7FFF_FFFF - $urandom_range(9)
                                 : 32'sh8000_0000 + $urandom_range(9);
        default: v = $signed($urandom_range(100000));
      endcase
      send_item(next_time, v);
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1;
        repeat (30000) @(negedge clk);
        recv_hold = 0;
      end
      test_random(12);
    join
    wait_idle();
  endtask

  initial begin
    sample.valid = 1'b0;
    sample.arrival_time = '0;
    sample.sample_value = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    stats.ready = 1'b0;
    recv_hold = 0;
    error_count = 0;
    results_seen = 0;
    items_sent = 0;
    quiet_cycles = 0;
    win_oldest = 0;
    win_count = 0;
    last_arrival = 0;
    have_last = 0;
    window_len = WINDOW_RESET;
    gap_mode = 0;
    next_time = 0;
    send_idle_pct = 38;
    recv_idle_pct = 61;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_long_window();
    write_reg(REG_WINDOW, 32'd3000);
    test_random(90);
    wait_idle();
    send_idle_pct = 61;
    recv_idle_pct = 38;
    write_reg(REG_INTERVAL, 32'd1);
    write_reg(REG_WINDOW, 32'd20000);
    test_random(90);
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_INTERVAL, 32'd0);
    write_reg(REG_WINDOW, 32'd1);
    test_random(60);
    test_backpressure();
    wait_idle();

    $display("sent %0d items, checked %0d results over several window and mode settings",
             items_sent, results_seen);
    if (error_count == 0 && expected_stats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("errors %0d, left over %0d", error_count, expected_stats.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sliding_window_statistics.f]
+incdir+sv
sv/sws_pkg.sv
sv/sws_if.sv
sv/sws_div.sv
sv/sliding_window_statistics.sv
sv/sws_check.sv
verif/tb_sliding_window_statistics.sv
